// ----- src/sqtu_pkg.sv -----
package sqtu_pkg;

    // table geometry
    localparam int STATE_W     = 16;
    localparam int NUM_STATES  = 1 << STATE_W;
    localparam int ACT_W       = 2;
    localparam int NUM_ACTIONS = 1 << ACT_W;
    localparam int CNT_W       = ACT_W + 1;
    localparam int Q_W         = 32;
    localparam int FRAC_W      = 16;
    localparam int ROW_W       = NUM_ACTIONS * Q_W;

    // update arithmetic widths
    localparam int DIFF_W = Q_W + 3;
    localparam int PROD_W = FRAC_W + 1 + DIFF_W;
    localparam int SUM_W  = DIFF_W + 1;

    // stream words
    localparam int OP_W       = 2;
    localparam int IN_CS_LSB  = 0;
    localparam int IN_CA_LSB  = IN_CS_LSB + STATE_W;
    localparam int IN_NS_LSB  = IN_CA_LSB + ACT_W;
    localparam int IN_RW_LSB  = IN_NS_LSB + STATE_W;
    localparam int IN_DR_LSB  = IN_RW_LSB + Q_W;
    localparam int IN_RA_LSB  = IN_DR_LSB + FRAC_W;
    localparam int IN_USED_W  = IN_RA_LSB + ACT_W;
    localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_CA_LSB = 0;
    localparam int OUT_Q_LSB  = OUT_CA_LSB + ACT_W;
    localparam int OUT_USED_W = OUT_Q_LSB + Q_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // configuration
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [FRAC_W-1:0] LEARN_RESET    = 16'd6554;
    localparam logic [FRAC_W-1:0] DISCOUNT_RESET = 16'd64881;
    localparam logic [FRAC_W-1:0] EXPLORE_RESET  = 16'd32768;
    localparam logic [CNT_W-1:0]  ACTIONS_RESET  = 3'd3;

    typedef logic signed [Q_W-1:0] q_t;
    typedef q_t [NUM_ACTIONS-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_CHOOSE = 2'd0,
        OP_STEP   = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN    = 2'd0,
        CFG_DISCOUNT = 2'd1,
        CFG_EXPLORE  = 2'd2,
        CFG_ACTIONS  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PICK,
        ST_LOAD,
        ST_TARGET,
        ST_SCALE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              en;
        logic [FRAC_W-1:0] coef;
        logic signed [DIFF_W-1:0] operand;
    } mac_ctl_t;

endpackage

// ----- src/sqtu_ram.sv -----
module sqtu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sqtu_select.sv -----
module sqtu_select
    import sqtu_pkg::*;
(
    input  row_t              row,
    input  logic [CNT_W-1:0]  actions_in_use,
    input  logic [FRAC_W-1:0] explore_rate,
    input  logic [FRAC_W-1:0] explore_draw,
    input  logic [ACT_W-1:0]  random_action,
    output logic [ACT_W-1:0]  choice,
    output logic              explored,
    output q_t                choice_q
);

    logic [CNT_W-1:0] count;
    logic [ACT_W-1:0] rnd_mod;
    logic [ACT_W-1:0] best;
    q_t               best_q;

    // zero acts as one action, anything above the table width saturates
    always_comb
    begin
        if (actions_in_use == '0)
        begin
            count = CNT_W'(1);
        end
        else if (actions_in_use > CNT_W'(NUM_ACTIONS))
        begin
            count = CNT_W'(NUM_ACTIONS);
        end
        else
        begin
            count = actions_in_use;
        end
    end

    always_comb
    begin
        unique case (count)
            3'd1:    rnd_mod = '0;
            3'd2:    rnd_mod = {1'b0, random_action[0]};
            3'd3:    rnd_mod = (random_action == 2'd3) ? '0 : random_action;
            default: rnd_mod = random_action;
        endcase
    end

    // lowest index wins on ties
    always_comb
    begin
        best   = '0;
        best_q = $signed(row[0]);
        for (int i = 1; i < NUM_ACTIONS; i++)
        begin
            if ((CNT_W'(i) < count) && ($signed(row[i]) > best_q))
            begin
                best   = ACT_W'(i);
                best_q = $signed(row[i]);
            end
        end
    end

    assign explored = (explore_draw < explore_rate);
    assign choice   = explored ? rnd_mod : best;
    assign choice_q = $signed(row[choice]);

endmodule

// ----- src/sqtu_mac.sv -----
module sqtu_mac
    import sqtu_pkg::*;
(
    input  logic                     clk,
    input  mac_ctl_t                 ctl,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] coef_ext;
    logic signed [PROD_W-1:0] operand_ext;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign coef_ext    = PROD_W'($signed({1'b0, ctl.coef}));
    assign operand_ext = PROD_W'(ctl.operand);
    assign prod_next   = coef_ext * operand_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- src/sarsa_q_table_update_unit.sv -----
// sarsa q-table update unit
// input stream s_*: one word per command, operation in s_tuser, other fields in
// s_tdata. output stream m_*: one word per command, explored flag in m_tuser.
// config channel cfg_*: always ready, write while no command is in flight.
// the table is one row of four q16.16 entries per state in a single ram with
// a registered read port; a shared multiplier does both scalings of the update.
// choose, read and the unused operation go through row read, then select and
// load the output register. the step operation goes through next-state row
// read, select, current-row read and gamma multiply, target minus prediction,
// alpha multiply, then saturate and write back. s_tready is high only between
// commands, so a new command is not taken until the last one has finished, a
// limit set by the single ram read port and the one shared multiplier.
// after reset the block walks all 65536 rows writing zero, one row per cycle,
// with s_tready low; config writes are still taken then.
// if m_tready is low with a result waiting, the next command is still taken
// and runs up to its final cycle, where it holds until the output frees up.
module sarsa_q_table_update_unit
    import sqtu_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // cur_state, cur_action, next_state, reward_value, explore_draw, random_action
    input  logic [IN_DATA_W-1:0]    s_tdata,
    // operation
    input  logic [OP_W-1:0]         s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // chosen_action, q_value
    output logic [OUT_DATA_W-1:0]   m_tdata,
    // explored
    output logic                    m_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [STATE_W-1:0] clr_addr_reg;

    logic [FRAC_W-1:0] learn_reg;
    logic [FRAC_W-1:0] discount_reg;
    logic [FRAC_W-1:0] explore_reg;
    logic [CNT_W-1:0]  actions_reg;

    op_t                op_reg;
    logic [STATE_W-1:0] cur_state_reg;
    logic [ACT_W-1:0]   cur_action_reg;
    logic [Q_W-1:0]     reward_reg;
    logic [FRAC_W-1:0]  draw_reg;
    logic [ACT_W-1:0]   rnd_reg;

    logic [ACT_W-1:0]        choice_reg;
    logic                    expl_reg;
    q_t                      qnext_reg;
    q_t                      predict_reg;
    row_t                    row_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;

    logic             out_valid_reg;
    logic [ACT_W-1:0] out_action_reg;
    logic             out_expl_reg;
    q_t               out_q_reg;

    logic             out_free;
    logic             accept;
    logic             out_load;
    logic [ACT_W-1:0] out_action;
    logic             out_expl;
    q_t               out_q;

    logic               ram_wr_en;
    logic [STATE_W-1:0] ram_wr_addr;
    row_t               ram_wr_row;
    logic               ram_rd_en;
    logic [STATE_W-1:0] ram_rd_addr;
    logic [ROW_W-1:0]   ram_rd_data;
    row_t               rd_row;

    logic [ACT_W-1:0] sel_choice;
    logic             sel_expl;
    q_t               sel_q;

    mac_ctl_t                 mac_ctl;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [PROD_W-1:0] prod_scaled;
    logic signed [SUM_W-1:0]  sum;
    q_t                       sum_sat;

    assign rd_row   = row_t'(ram_rd_data);
    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sqtu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_STATES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ROW_W'(ram_wr_row)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sqtu_select u_select (
        .row            (rd_row),
        .actions_in_use (actions_reg),
        .explore_rate   (explore_reg),
        .explore_draw   (draw_reg),
        .random_action  (rnd_reg),
        .choice         (sel_choice),
        .explored       (sel_expl),
        .choice_q       (sel_q)
    );

    sqtu_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .prod (mac_prod)
    );

    // floor shift drops the q0.16 scale of the coefficient
    assign prod_scaled = mac_prod >>> FRAC_W;
    assign diff_next   = DIFF_W'($signed(reward_reg)) + DIFF_W'(prod_scaled)
                         - DIFF_W'(predict_reg);
    assign sum         = SUM_W'(predict_reg) + SUM_W'(prod_scaled);

    always_comb
    begin
        if (sum > SUM_W'(32'sh7fffffff))
        begin
            sum_sat = 32'sh7fffffff;
        end
        else if (sum < -SUM_W'(33'sh080000000))
        begin
            sum_sat = 32'sh80000000;
        end
        else
        begin
            sum_sat = Q_W'(sum);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == STATE_W'(NUM_STATES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (op_reg == OP_STEP)
                begin
                    state_next = ST_LOAD;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:   state_next = ST_TARGET;
            ST_TARGET: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_state_reg;
        ram_wr_row  = row_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cur_state_reg;
        mac_ctl     = '{en: 1'b0, coef: discount_reg,
                        operand: DIFF_W'(qnext_reg)};
        out_load    = 1'b0;
        out_action  = '0;
        out_expl    = 1'b0;
        out_q       = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_row  = '0;
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_rd_en = s_tvalid;
                if (op_t'(s_tuser) == OP_STEP)
                begin
                    ram_rd_addr = s_tdata[IN_NS_LSB +: STATE_W];
                end
                else
                begin
                    ram_rd_addr = s_tdata[IN_CS_LSB +: STATE_W];
                end
            end
            ST_PICK:
            begin
                if (op_reg == OP_STEP)
                begin
                    ram_rd_en = 1'b1;
                end
                else
                begin
                    out_load = out_free;
                    unique case (op_reg)
                        OP_CHOOSE:
                        begin
                            out_action = sel_choice;
                            out_expl   = sel_expl;
                            out_q      = sel_q;
                        end
                        OP_READ:
                        begin
                            out_q = $signed(rd_row[cur_action_reg]);
                        end
                        default:
                        begin
                            out_q = '0;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                mac_ctl.en = 1'b1;
            end
            ST_TARGET:
            begin
            end
            ST_SCALE:
            begin
                mac_ctl = '{en: 1'b1, coef: learn_reg, operand: diff_reg};
            end
            ST_WRITE:
            begin
                ram_wr_en  = out_free;
                ram_wr_row[cur_action_reg] = sum_sat;
                out_load   = out_free;
                out_action = choice_reg;
                out_expl   = expl_reg;
                out_q      = sum_sat;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            learn_reg     <= LEARN_RESET;
            discount_reg  <= DISCOUNT_RESET;
            explore_reg   <= EXPLORE_RESET;
            actions_reg   <= ACTIONS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + STATE_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_LEARN:    learn_reg    <= cfg_data[FRAC_W-1:0];
                    CFG_DISCOUNT: discount_reg <= cfg_data[FRAC_W-1:0];
                    CFG_EXPLORE:  explore_reg  <= cfg_data[FRAC_W-1:0];
                    CFG_ACTIONS:  actions_reg  <= cfg_data[CNT_W-1:0];
                    default:      actions_reg  <= actions_reg;
                endcase
            end
        end
    end

    // command and datapath words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= op_t'(s_tuser);
            cur_state_reg  <= s_tdata[IN_CS_LSB +: STATE_W];
            cur_action_reg <= s_tdata[IN_CA_LSB +: ACT_W];
            reward_reg     <= s_tdata[IN_RW_LSB +: Q_W];
            draw_reg       <= s_tdata[IN_DR_LSB +: FRAC_W];
            rnd_reg        <= s_tdata[IN_RA_LSB +: ACT_W];
        end
        if (state_reg == ST_PICK)
        begin
            choice_reg <= sel_choice;
            expl_reg   <= sel_expl;
            qnext_reg  <= sel_q;
        end
        if (state_reg == ST_LOAD)
        begin
            row_reg     <= rd_row;
            predict_reg <= $signed(rd_row[cur_action_reg]);
        end
        if (state_reg == ST_TARGET)
        begin
            diff_reg <= diff_next;
        end
        if (out_load)
        begin
            out_action_reg <= out_action;
            out_expl_reg   <= out_expl;
            out_q_reg      <= out_q;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_expl_reg;
    assign m_tdata   = OUT_DATA_W'({out_q_reg, out_action_reg});

endmodule

// ----- tb/sarsa_q_table_update_unit_test.sv -----
`timescale 1ns / 100ps

module sarsa_q_table_update_unit_test;

    import sqtu_pkg::*;

    localparam int unsigned STATE_POOL  = 16;
    localparam longint      SAT_MAX     = 64'sd2147483647;
    localparam longint      SAT_MIN     = -64'sd2147483648;
    localparam int unsigned RUN_LIMIT   = 10_000_000;

    typedef struct packed {
        op_t                op;
        logic [STATE_W-1:0] cur_state;
        logic [ACT_W-1:0]   cur_action;
        logic [STATE_W-1:0] next_state;
        logic [Q_W-1:0]     reward;
        logic [FRAC_W-1:0]  draw;
        logic [ACT_W-1:0]   rnd_action;
    } sarsa_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             explored;
        logic [Q_W-1:0]   q_value;
    } sarsa_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // cur_state, cur_action, next_state, reward_value, explore_draw, random_action
    logic [IN_DATA_W-1:0]  s_tdata;
    // operation
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // chosen_action, q_value
    logic [OUT_DATA_W-1:0] m_tdata;
    // explored
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow of the q-table and the settings, updated as words are accepted
    int                    q_shadow [NUM_STATES*NUM_ACTIONS];
    logic [FRAC_W-1:0]     learn_cfg    = LEARN_RESET;
    logic [FRAC_W-1:0]     discount_cfg = DISCOUNT_RESET;
    logic [FRAC_W-1:0]     explore_cfg  = EXPLORE_RESET;
    logic [CNT_W-1:0]      actions_cfg  = ACTIONS_RESET;

    sarsa_result_t         q_results_due [$];
    int                    mismatches    = 0;
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_idle_pct = 0;

    sarsa_q_table_update_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int entry(input logic [STATE_W-1:0] st, input logic [ACT_W-1:0] act);
        return int'(st) * NUM_ACTIONS + int'(act);
    endfunction

    // epsilon-greedy choice over the first actions of a row
    function automatic logic [ACT_W-1:0] pick_action(
        input  logic [STATE_W-1:0] st,
        input  logic [FRAC_W-1:0]  draw,
        input  logic [ACT_W-1:0]   rnd,
        output logic               took_random
    );
        int unsigned span;
        int unsigned best;
        span = actions_cfg;
        if (span == 0)
            span = 1;
        if (span > NUM_ACTIONS)
            span = NUM_ACTIONS;
        if (draw < explore_cfg)
        begin
            took_random = 1'b1;
            return ACT_W'(rnd % span);
        end
        took_random = 1'b0;
        best = 0;
        for (int unsigned i = 1; i < span; i++)
            if (q_shadow[entry(st, ACT_W'(i))] > q_shadow[entry(st, ACT_W'(best))])
                best = i;
        return ACT_W'(best);
    endfunction

    function automatic sarsa_result_t predict_sarsa_step(input sarsa_cmd_t cmd);
        sarsa_result_t r;
        int            s;
        longint        predict;
        longint        target;
        longint        sum;
        r = '0;
        case (cmd.op)
            OP_CHOOSE:
            begin
                r.action  = pick_action(cmd.cur_state, cmd.draw, cmd.rnd_action, r.explored);
                r.q_value = q_shadow[entry(cmd.cur_state, r.action)];
            end
            OP_STEP:
            begin
                s = entry(cmd.cur_state, cmd.cur_action);
                // next action is chosen from the row before the write-back
                r.action = pick_action(cmd.next_state, cmd.draw, cmd.rnd_action, r.explored);
                predict  = q_shadow[s];
                target   = longint'($signed(cmd.reward))
                         + ((longint'(discount_cfg)
                             * longint'(q_shadow[entry(cmd.next_state, r.action)])) >>> 16);
                sum      = predict + ((longint'(learn_cfg) * (target - predict)) >>> 16);
                if (sum > SAT_MAX)
                    sum = SAT_MAX;
                if (sum < SAT_MIN)
                    sum = SAT_MIN;
                q_shadow[s] = int'(sum);
                r.q_value   = sum[Q_W-1:0];
            end
            OP_READ:
                r.q_value = q_shadow[entry(cmd.cur_state, cmd.cur_action)];
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic sarsa_cmd_t cmd_of(
        input op_t         op,
        input int unsigned st,
        input int unsigned act,
        input int unsigned ns,
        input logic [31:0] rw,
        input int unsigned draw,
        input int unsigned rnd
    );
        sarsa_cmd_t c;
        c.op         = op;
        c.cur_state  = STATE_W'(st);
        c.cur_action = ACT_W'(act);
        c.next_state = STATE_W'(ns);
        c.reward     = rw;
        c.draw       = FRAC_W'(draw);
        c.rnd_action = ACT_W'(rnd);
        return c;
    endfunction

    function automatic logic [STATE_W-1:0] pool_state();
        if ($urandom_range(99) < 85)
            return STATE_W'($urandom_range(STATE_POOL - 1));
        return STATE_W'($urandom_range(16'hFFFF));
    endfunction

    task automatic report_mismatch(input string what, input longint expected, input longint actual);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, expected, actual);
        mismatches++;
    endtask

    // one command word; valid stays high into the next call unless a gap is drawn
    task automatic send_cmd(input sarsa_cmd_t cmd);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_CS_LSB +: STATE_W] = cmd.cur_state;
        d[IN_CA_LSB +: ACT_W]   = cmd.cur_action;
        d[IN_NS_LSB +: STATE_W] = cmd.next_state;
        d[IN_RW_LSB +: Q_W]     = cmd.reward;
        d[IN_DR_LSB +: FRAC_W]  = cmd.draw;
        d[IN_RA_LSB +: ACT_W]   = cmd.rnd_action;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = d;
        s_tuser  = cmd.op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        q_results_due.push_back(predict_sarsa_step(cmd));
    endtask

    // drop valid and wait for every pending result
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (q_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_setting(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LEARN:    learn_cfg    = value;
            CFG_DISCOUNT: discount_cfg = value;
            CFG_EXPLORE:  explore_cfg  = value;
            CFG_ACTIONS:  actions_cfg  = value[CNT_W-1:0];
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(
        input logic [CFG_DATA_W-1:0] learn,
        input logic [CFG_DATA_W-1:0] disc,
        input logic [CFG_DATA_W-1:0] expl,
        input logic [CFG_DATA_W-1:0] acts
    );
        settle();
        write_setting(CFG_LEARN, learn);
        write_setting(CFG_DISCOUNT, disc);
        write_setting(CFG_EXPLORE, expl);
        write_setting(CFG_ACTIONS, acts);
    endtask

    // cleared table, reset settings, choice rule edges and the unused operation
    task automatic test_after_reset();
        send_cmd(cmd_of(OP_READ, 0, 0, 0, 32'h0, 0, 0));
        send_cmd(cmd_of(OP_READ, 16'hFFFF, 3, 0, 32'h0, 0, 0));
        send_cmd(cmd_of(OP_CHOOSE, 7, 0, 0, 32'h0, 16'hFFFF, 3));
        // random action wraps modulo the action count
        send_cmd(cmd_of(OP_CHOOSE, 7, 0, 0, 32'h0, 0, 3));
        send_cmd(cmd_of(OP_CHOOSE, 7, 0, 0, 32'h0, 32767, 2));
        // draw equal to epsilon is not below it
        send_cmd(cmd_of(OP_CHOOSE, 7, 0, 0, 32'h0, 32768, 2));
        send_cmd(cmd_of(OP_NONE, 16'hFFFF, 3, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 3));
    endtask

    task automatic test_update_rules();
        // action beyond the count is still updated
        send_cmd(cmd_of(OP_STEP, 9, 3, 9, 32'h0001_0000, 16'hFFFF, 0));
        // same row for current and next state uses the old values
        send_cmd(cmd_of(OP_STEP, 9, 1, 9, 32'hFFFE_0000, 16'hFFFF, 0));
        send_cmd(cmd_of(OP_STEP, 9, 0, 9, 32'h0003_0000, 16'hFFFF, 0));
        send_cmd(cmd_of(OP_CHOOSE, 9, 0, 0, 32'h0, 16'hFFFF, 0));
        send_cmd(cmd_of(OP_READ, 9, 3, 0, 32'h0, 0, 0));
    endtask

    task automatic test_setting_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'd4);
        // drive one entry into both saturation limits
        repeat (3)
            send_cmd(cmd_of(OP_STEP, 100, 2, 100, 32'h7FFF_FFFF, 0, 1));
        repeat (3)
            send_cmd(cmd_of(OP_STEP, 100, 2, 100, 32'h8000_0000, 16'hFFFF, 3));
        send_cmd(cmd_of(OP_READ, 100, 2, 0, 32'h0, 0, 0));
        // zero actions act as one, zero learn rate leaves the entry alone
        apply_settings(16'h0000, 16'h8000, 16'hFFFF, 16'd0);
        send_cmd(cmd_of(OP_CHOOSE, 100, 0, 0, 32'h0, 16'hFFFF, 3));
        send_cmd(cmd_of(OP_CHOOSE, 100, 0, 0, 32'h0, 16'hFFFE, 3));
        send_cmd(cmd_of(OP_STEP, 100, 2, 100, 32'h7FFF_FFFF, 16'hFFFF, 0));
        // count above the table width saturates, upper data bits ignored
        apply_settings(16'h4000, 16'h0000, 16'h0000, 16'hA5F7);
        send_cmd(cmd_of(OP_CHOOSE, 100, 0, 0, 32'h0, 16'hFFFF, 0));
        send_cmd(cmd_of(OP_STEP, 101, 0, 100, 32'h0001_2345, 16'hFFFF, 0));
        send_cmd(cmd_of(OP_READ, 101, 0, 0, 32'h0, 0, 0));
    endtask

    // mostly updates over a small state pool so rows fill and the greedy path matters
    task automatic test_random_phase(
        input int unsigned n_items,
        input int unsigned send_pct,
        input int unsigned recv_pct
    );
        sarsa_cmd_t  cmd;
        int unsigned sel;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int unsigned k = 0; k < n_items; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                cmd.op = OP_STEP;
            else if (sel < 80)
                cmd.op = OP_CHOOSE;
            else if (sel < 95)
                cmd.op = OP_READ;
            else
                cmd.op = OP_NONE;
            cmd.cur_state  = pool_state();
            cmd.next_state = pool_state();
            cmd.cur_action = ACT_W'($urandom_range(3));
            cmd.rnd_action = ACT_W'($urandom_range(3));
            sel = $urandom_range(99);
            if (sel < 60)
                cmd.reward = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            else if (sel < 85)
                cmd.reward = $urandom();
            else if (sel < 90)
                cmd.reward = 32'h7FFF_FFFF;
            else if (sel < 95)
                cmd.reward = 32'h8000_0000;
            else
                cmd.reward = 32'h0;
            if ($urandom_range(9) == 0)
                cmd.draw = explore_cfg - FRAC_W'($urandom_range(1));
            else
                cmd.draw = FRAC_W'($urandom_range(16'hFFFF));
            send_cmd(cmd);
        end
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        sarsa_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (q_results_due.size() == 0)
                report_mismatch("unexpected result word, q_value", 0,
                                $signed(m_tdata[OUT_Q_LSB +: Q_W]));
            else
            begin
                due = q_results_due.pop_front();
                if (m_tdata[OUT_CA_LSB +: ACT_W] !== due.action)
                    report_mismatch("chosen_action", due.action, m_tdata[OUT_CA_LSB +: ACT_W]);
                if (m_tuser !== due.explored)
                    report_mismatch("explored", due.explored, m_tuser);
                if (m_tdata[OUT_Q_LSB +: Q_W] !== due.q_value)
                    report_mismatch("q_value", $signed(due.q_value),
                                    $signed(m_tdata[OUT_Q_LSB +: Q_W]));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_CHOOSE;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LEARN;
        cfg_data  = '0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_update_rules();
        test_setting_extremes();

        apply_settings(CFG_DATA_W'($urandom_range(16'hFFFF)), CFG_DATA_W'($urandom_range(16'hFFFF)),
                       CFG_DATA_W'($urandom_range(16'hFFFF)), CFG_DATA_W'($urandom_range(1, 4)));
        test_random_phase(434, 33, 67);
        apply_settings(CFG_DATA_W'($urandom_range(16'h8000, 16'hFFFF)), 16'hFFFF,
                       CFG_DATA_W'($urandom_range(16'hFFFF)), CFG_DATA_W'($urandom_range(7)));
        test_random_phase(433, 67, 33);
        apply_settings(LEARN_RESET, DISCOUNT_RESET, EXPLORE_RESET, CFG_DATA_W'(ACTIONS_RESET));
        test_random_phase(433, 0, 0);

        settle();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("** sarsa_q_table_update_unit: PASSED **");
        else
            $display("** sarsa_q_table_update_unit: FAILED **");
        $finish;
    end

    // covers the clearing pass after reset plus every word at its slowest
    initial
    begin
        #(RUN_LIMIT);
        $display("** sarsa_q_table_update_unit: FAILED **");
        $finish;
    end

endmodule
